// ===== design/es_descriptor_parser_core_assert.svh =====
// Assertion macros used by the parser's top-level RTL file.
// Define ASSERT_OFF to compile the checks out.
`ifndef ES_DESCRIPTOR_PARSER_CORE_ASSERT_SVH
`define ES_DESCRIPTOR_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset
`define ESDP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ESDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ESDP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define ESDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/esdp_pkg.sv =====
package esdp_pkg;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 28;
    localparam int RATE_W   = 17;
    localparam int CHAN_W   = 4;
    localparam int CNT_W    = 4;
    localparam int GROUP_W  = 3;
    localparam int M_DATA_W = 64;

    // Length field: 7-bit groups, at most this many
    localparam logic [GROUP_W-1:0] LEN_GROUPS_MAX = 3'd4;

    // Fixed field byte counts
    localparam logic [CNT_W-1:0] HEAD_BYTES = 4'd4;
    localparam logic [CNT_W-1:0] ES_BYTES   = 4'd3;
    localparam logic [CNT_W-1:0] DEC_BYTES  = 4'd13;

    // Descriptor tags
    localparam logic [BYTE_W-1:0] TAG_ES   = 8'h03;
    localparam logic [BYTE_W-1:0] TAG_DEC  = 8'h04;
    localparam logic [BYTE_W-1:0] TAG_SPEC = 8'h05;

    // Summary status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TAG3 = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TAG4 = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_TAG5 = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

    // Result word kinds
    localparam logic KIND_CFG = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    // Register map
    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_AAC = 2'd0;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One queue entry: what a byte asks the back end to emit
    typedef struct packed {
        logic                has_cfg;
        logic                has_sum;
        logic [BYTE_W-1:0]   cfg_byte;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   size;
        logic                aac_ok;
        logic [3:0]          rate_idx;
        logic [CHAN_W-1:0]   chan;
    } esdp_op_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } esdp_q_stat_t;

    // Sampling frequency index to hertz
    function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
        logic [RATE_W-1:0] r;
        unique case (idx)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            4'd12:   r = 17'd7350;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/esdp_front.sv =====
module esdp_front import esdp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,
    input  logic              is_aac,
    input  esdp_q_stat_t      q_stat,
    output logic              push,
    output esdp_op_t          op
);

    // Parse phases
    localparam logic [3:0] PH_HEAD   = 4'd0;
    localparam logic [3:0] PH_TAG3   = 4'd1;
    localparam logic [3:0] PH_LEN3   = 4'd2;
    localparam logic [3:0] PH_ES     = 4'd3;
    localparam logic [3:0] PH_TAG4   = 4'd4;
    localparam logic [3:0] PH_LEN4   = 4'd5;
    localparam logic [3:0] PH_DEC    = 4'd6;
    localparam logic [3:0] PH_TAG5   = 4'd7;
    localparam logic [3:0] PH_LEN5   = 4'd8;
    localparam logic [3:0] PH_CONFIG = 4'd9;
    localparam logic [3:0] PH_SKIP   = 4'd10;

    logic [3:0]          phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next, cnt_dec;
    logic [SIZE_W-1:0]   acc_reg, acc_next, acc_take;
    logic [GROUP_W-1:0]  grp_reg, grp_next, grp_inc;
    logic [SIZE_W-1:0]   left_reg, left_next, left_dec;
    logic [SIZE_W-1:0]   stored_reg, stored_next;
    logic [15:0]         first_reg, first_next;
    logic [1:0]          rcv_reg, rcv_next;
    logic [STATUS_W-1:0] held_reg, held_next;
    logic                accept;
    logic                len_done;
    logic [BYTE_W-1:0]   b0, b1;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Shared step helpers
    assign cnt_dec  = (cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
    assign acc_take = {acc_reg[SIZE_W-8:0], s_tdata[6:0]};
    assign grp_inc  = grp_reg + 1'b1;
    assign len_done = !(s_tdata[7] && (grp_inc < LEN_GROUPS_MAX));

    // Byte classification and state update
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        grp_next    = grp_reg;
        left_next   = left_reg;
        stored_next = stored_reg;
        first_next  = first_reg;
        rcv_next    = rcv_reg;
        held_next   = held_reg;
        op          = '0;

        unique case (phase_reg)
            PH_HEAD: begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0) phase_next = PH_TAG3;
            end
            PH_ES: begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0) phase_next = PH_TAG4;
            end
            PH_DEC: begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0) phase_next = PH_TAG5;
            end
            PH_TAG3: begin
                if (s_tdata == TAG_ES) begin
                    phase_next = PH_LEN3;
                    acc_next   = '0;
                    grp_next   = '0;
                end else begin
                    held_next  = ST_BAD_TAG3;
                    phase_next = PH_SKIP;
                end
            end
            PH_TAG4: begin
                if (s_tdata == TAG_DEC) begin
                    phase_next = PH_LEN4;
                    acc_next   = '0;
                    grp_next   = '0;
                end else begin
                    held_next  = ST_BAD_TAG4;
                    phase_next = PH_SKIP;
                end
            end
            PH_TAG5: begin
                if (s_tdata == TAG_SPEC) begin
                    phase_next = PH_LEN5;
                    acc_next   = '0;
                    grp_next   = '0;
                end else begin
                    held_next  = ST_BAD_TAG5;
                    phase_next = PH_SKIP;
                end
            end
            PH_LEN3: begin
                acc_next = acc_take;
                grp_next = len_done ? '0 : grp_inc;
                if (len_done) begin
                    phase_next = PH_ES;
                    cnt_next   = ES_BYTES;
                end
            end
            PH_LEN4: begin
                acc_next = acc_take;
                grp_next = len_done ? '0 : grp_inc;
                if (len_done) begin
                    phase_next = PH_DEC;
                    cnt_next   = DEC_BYTES;
                end
            end
            PH_LEN5: begin
                acc_next = acc_take;
                grp_next = len_done ? '0 : grp_inc;
                if (len_done) begin
                    stored_next = acc_take;
                    left_next   = acc_take;
                    if (acc_take == '0) begin
                        held_next  = ST_EMPTY;
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_CONFIG;
                    end
                end
            end
            PH_CONFIG: begin
                // keep the first two bytes, count received ones up to two
                if (rcv_reg != 2'd2) begin
                    first_next = {first_reg[7:0], s_tdata};
                    rcv_next   = rcv_reg + 1'b1;
                end
                op.has_cfg  = 1'b1;
                op.cfg_byte = s_tdata;
                left_next   = left_dec;
                if (left_dec == '0) begin
                    held_next  = ST_OK;
                    phase_next = PH_SKIP;
                end
            end
            default: phase_next = PH_SKIP;
        endcase

        // End-of-atom summary from the updated state
        if (rcv_next == 2'd2) begin
            b0 = first_next[15:8];
            b1 = first_next[7:0];
        end else begin
            b0 = first_next[7:0];
            b1 = '0;
        end
        op.has_sum  = s_tlast;
        op.status   = s_tlast ? ((phase_next == PH_SKIP) ? held_next : ST_TRUNC) : ST_OK;
        op.size     = s_tlast ? stored_next : '0;
        op.aac_ok   = s_tlast && is_aac && (stored_next > SIZE_W'(1));
        op.rate_idx = {b0[2:0], b1[7]};
        op.chan     = b1[6:3];
    end

    assign push = accept && (op.has_cfg || op.has_sum);

    // Control state; an atom end restores the start-of-atom values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD;
            cnt_reg    <= HEAD_BYTES;
            acc_reg    <= '0;
            grp_reg    <= '0;
            left_reg   <= '0;
            stored_reg <= '0;
            first_reg  <= '0;
            rcv_reg    <= '0;
            held_reg   <= ST_OK;
        end else if (accept) begin
            if (s_tlast) begin
                phase_reg  <= PH_HEAD;
                cnt_reg    <= HEAD_BYTES;
                acc_reg    <= '0;
                grp_reg    <= '0;
                left_reg   <= '0;
                stored_reg <= '0;
                first_reg  <= '0;
                rcv_reg    <= '0;
                held_reg   <= ST_OK;
            end else begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                acc_reg    <= acc_next;
                grp_reg    <= grp_next;
                left_reg   <= left_next;
                stored_reg <= stored_next;
                first_reg  <= first_next;
                rcv_reg    <= rcv_next;
                held_reg   <= held_next;
            end
        end
    end

endmodule

// ===== design/esdp_queue.sv =====
module esdp_queue import esdp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  esdp_op_t     push_op,
    input  logic         pop,
    output esdp_op_t     head_op,
    output esdp_q_stat_t q_stat
);

    esdp_op_t           entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_op      = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_op;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/esdp_back.sv =====
module esdp_back import esdp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  esdp_op_t            head_op,
    input  esdp_q_stat_t        q_stat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] config_byte, [10:8] parse_status, [38:11] config_size,
    // [55:39] audio_rate, [59:56] channel_count, [63:60] zero
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,   // [0] item_kind
    output logic                m_tlast
);

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;
    logic                cfg_sent_reg, cfg_sent_next;
    logic                load;
    logic                send_cfg;
    logic [RATE_W-1:0]   rate;
    logic [CHAN_W-1:0]   chan;

    assign load     = !m_tvalid_reg || m_tready;
    assign send_cfg = head_op.has_cfg && !cfg_sent_reg;
    assign rate     = head_op.aac_ok ? rate_lookup(head_op.rate_idx) : '0;
    assign chan     = head_op.aac_ok ? head_op.chan : '0;

    // Expand a queue entry into a config word, a summary word, or both
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        cfg_sent_next = cfg_sent_reg;
        pop           = 1'b0;
        if (load) begin
            m_tvalid_next = !q_stat.empty;
            if (!q_stat.empty) begin
                if (send_cfg) begin
                    m_tdata_next  = {{(M_DATA_W-BYTE_W){1'b0}}, head_op.cfg_byte};
                    m_tuser_next  = KIND_CFG;
                    m_tlast_next  = 1'b0;
                    pop           = !head_op.has_sum;
                    cfg_sent_next = head_op.has_sum;
                end else begin
                    m_tdata_next  = {4'b0, chan, rate, head_op.size, head_op.status,
                                     {BYTE_W{1'b0}}};
                    m_tuser_next  = KIND_SUM;
                    m_tlast_next  = 1'b1;
                    pop           = 1'b1;
                    cfg_sent_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            cfg_sent_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            cfg_sent_reg <= cfg_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== design/es_descriptor_parser_core.sv =====
// Path: a byte accepted by the front parser is written into a queue entry, and its
// result word is then loaded into the output register before it is valid.
// Throughput: one byte per cycle; the front parser takes a byte every cycle
// unless the four-entry queue is full. A config byte that also ends the atom
// yields two words, which the output register sends one after the other.
// Reset: synchronous, active low; clears parser state, queue, output valid, AAC flag.
`include "es_descriptor_parser_core_assert.svh"

module es_descriptor_parser_core import esdp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // byte stream in
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,   // end_of_atom
    // result words out
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] config_byte, [10:8] parse_status, [38:11] config_size,
    // [55:39] audio_rate, [59:56] channel_count, [63:60] zero
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,   // [0] item_kind
    output logic                m_tlast,   // is_last
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic         is_aac_reg;
    logic         push, pop;
    esdp_op_t     push_op, head_op;
    esdp_q_stat_t q_stat;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_AAC) ? {31'b0, is_aac_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_aac_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_AAC) begin
            is_aac_reg <= pwdata[0];
        end
    end

    esdp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .is_aac   (is_aac_reg),
        .q_stat   (q_stat),
        .push     (push),
        .op       (push_op)
    );

    esdp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat)
    );

    esdp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_op  (head_op),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Checks
    `ESDP_ASSERT_NOW(a_q_bound, aclk, aresetn, 1'b1,
                     q_stat.count <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
    `ESDP_ASSERT_NOW(a_last_is_sum, aclk, aresetn, m_tvalid,
                     m_tlast == m_tuser, "last flag and kind disagree")
    `ESDP_ASSERT_NOW(a_cfg_clean, aclk, aresetn, m_tvalid && m_tuser == KIND_CFG,
                     m_tdata[M_DATA_W-1:BYTE_W] == '0, "config word carries summary bits")
    `ESDP_ASSERT_NEXT(a_full_stall, aclk, aresetn, q_stat.full && !pop,
                      !s_tready, "input taken while queue full")

endmodule

// ===== tb/es_descriptor_parser_core_tb.sv =====
`timescale 1ns / 1ps

module es_descriptor_parser_core_tb;
    import esdp_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no word moving anywhere
    localparam int RANDOM_BYTES = 100;

    // Parser position within one atom
    typedef enum logic [3:0] {
        AT_HEAD, AT_TAG_ES, AT_LEN_ES, AT_ES_FIXED, AT_TAG_DEC, AT_LEN_DEC,
        AT_DEC_FIXED, AT_TAG_SPEC, AT_LEN_SPEC, AT_CONFIG, AT_DISCARD
    } atom_pos_t;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   cfg;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   size;
        logic [RATE_W-1:0]   rate;
        logic [CHAN_W-1:0]   chan;
        logic                last;
    } parse_word_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    es_descriptor_parser_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock, 10 ns period
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the parser state
    logic                aac_cfg;
    atom_pos_t           pos;
    logic [CNT_W-1:0]    fixed_left;
    logic [SIZE_W-1:0]   len_acc;
    logic [GROUP_W-1:0]  len_groups;
    logic [SIZE_W-1:0]   cfg_left;
    logic [SIZE_W-1:0]   cfg_size;
    logic [15:0]         cfg_head;
    logic [STATUS_W-1:0] held_status;
    logic [RATE_W-1:0]   rate_hz [16];

    parse_word_t pending_words[$];
    logic [7:0]  atom_bytes[$];

    int mismatches;
    int bytes_sent;
    int atoms_sent;
    int cfg_words_seen;
    int summaries_seen;
    int status_seen [8];
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_req;
    int rx_hold_left;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        pos         = AT_HEAD;
        fixed_left  = HEAD_BYTES;
        len_acc     = '0;
        len_groups  = '0;
        cfg_left    = '0;
        cfg_size    = '0;
        cfg_head    = '0;
        held_status = ST_OK;
    endfunction

    function automatic parse_word_t mk_word(input logic kind, input logic [7:0] cfg,
                                            input logic [STATUS_W-1:0] status,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [RATE_W-1:0] rate,
                                            input logic [CHAN_W-1:0] chan,
                                            input logic last);
        parse_word_t w;
        w.kind   = kind;
        w.cfg    = cfg;
        w.status = status;
        w.size   = size;
        w.rate   = rate;
        w.chan   = chan;
        w.last   = last;
        return w;
    endfunction

    // One 7-bit length group, MS group first; 1 when the length is complete
    function automatic bit length_done(input logic [7:0] b);
        len_acc    = {len_acc[SIZE_W-8:0], 7'd0} + SIZE_W'(b[6:0]);
        len_groups = len_groups + 1'b1;
        if (b[7] && len_groups < LEN_GROUPS_MAX)
            return 1'b0;
        len_groups = '0;
        return 1'b1;
    endfunction

    function automatic void match_tag(input logic [7:0] b, input logic [7:0] want,
                                      input atom_pos_t next, input logic [STATUS_W-1:0] bad);
        if (b == want) begin
            pos        = next;
            len_acc    = '0;
            len_groups = '0;
        end else begin
            held_status = bad;
            pos         = AT_DISCARD;
        end
    endfunction

    function automatic void skip_fixed(input atom_pos_t next);
        if (fixed_left != 0)
            fixed_left = fixed_left - 1'b1;
        if (fixed_left == 0)
            pos = next;
    endfunction

    // Works out the words that one accepted byte gives
    function automatic void predict_parse(input logic [7:0] d, input logic last);
        logic [SIZE_W-1:0]   got_n;
        logic [7:0]          b0;
        logic [7:0]          b1;
        logic [RATE_W-1:0]   rate;
        logic [CHAN_W-1:0]   chan;
        logic [STATUS_W-1:0] status;
        case (pos)
            AT_HEAD:      skip_fixed(AT_TAG_ES);
            AT_TAG_ES:    match_tag(d, TAG_ES, AT_LEN_ES, ST_BAD_TAG3);
            AT_LEN_ES: begin
                if (length_done(d)) begin
                    pos        = AT_ES_FIXED;
                    fixed_left = ES_BYTES;
                end
            end
            AT_ES_FIXED:  skip_fixed(AT_TAG_DEC);
            AT_TAG_DEC:   match_tag(d, TAG_DEC, AT_LEN_DEC, ST_BAD_TAG4);
            AT_LEN_DEC: begin
                if (length_done(d)) begin
                    pos        = AT_DEC_FIXED;
                    fixed_left = DEC_BYTES;
                end
            end
            AT_DEC_FIXED: skip_fixed(AT_TAG_SPEC);
            AT_TAG_SPEC:  match_tag(d, TAG_SPEC, AT_LEN_SPEC, ST_BAD_TAG5);
            AT_LEN_SPEC: begin
                if (length_done(d)) begin
                    cfg_size = len_acc;
                    cfg_left = len_acc;
                    if (len_acc == 0) begin
                        held_status = ST_EMPTY;
                        pos         = AT_DISCARD;
                    end else begin
                        pos = AT_CONFIG;
                    end
                end
            end
            AT_CONFIG: begin
                if (cfg_size - cfg_left < 2)
                    cfg_head = {cfg_head[7:0], d};
                pending_words.push_back(mk_word(KIND_CFG, d, ST_OK, '0, '0, '0, 1'b0));
                if (cfg_left != 0)
                    cfg_left = cfg_left - 1'b1;
                if (cfg_left == 0) begin
                    held_status = ST_OK;
                    pos         = AT_DISCARD;
                end
            end
            default:      pos = AT_DISCARD;
        endcase

        if (last) begin
            rate   = '0;
            chan   = '0;
            status = (pos == AT_DISCARD) ? held_status : ST_TRUNC;
            if (aac_cfg && cfg_size > 1) begin
                got_n = cfg_size - cfg_left;
                // with only one config byte in, it sits in the low half
                if (got_n >= 2) begin
                    b0 = cfg_head[15:8];
                    b1 = cfg_head[7:0];
                end else begin
                    b0 = cfg_head[7:0];
                    b1 = 8'h00;
                end
                rate = rate_hz[{b0[2:0], b1[7]}];
                chan = b1[6:3];
            end
            pending_words.push_back(mk_word(KIND_SUM, 8'h00, status, cfg_size, rate, chan,
                                            1'b1));
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("word %0d, %s: got 0x%0h, expected 0x%0h",
                                   cfg_words_seen + summaries_seen, name, got, want));
    endtask

    always @(posedge aclk) begin
        parse_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                report_error($sformatf("unexpected word, tdata 0x%0h tuser %0b tlast %0b",
                                       m_tdata, m_tuser, m_tlast));
            end else begin
                w = pending_words.pop_front();
                check_field("item_kind", 64'(m_tuser), 64'(w.kind));
                check_field("config_byte", 64'(m_tdata[7:0]), 64'(w.cfg));
                check_field("parse_status", 64'(m_tdata[10:8]), 64'(w.status));
                check_field("config_size", 64'(m_tdata[38:11]), 64'(w.size));
                check_field("audio_rate", 64'(m_tdata[55:39]), 64'(w.rate));
                check_field("channel_count", 64'(m_tdata[59:56]), 64'(w.chan));
                check_field("padding", 64'(m_tdata[63:60]), 64'h0);
                check_field("is_last", 64'(m_tlast), 64'(w.last));
                if (w.kind == KIND_SUM) begin
                    summaries_seen++;
                    status_seen[w.status]++;
                end else begin
                    cfg_words_seen++;
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing has moved for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("es_descriptor_parser_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic last);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_parse(d, last);
        bytes_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            s_tlast  <= 1'($urandom_range(1));
            repeat ($urandom_range(2)) @(negedge aclk);
        end
    endtask

    // Waits for the block to empty, then writes the AAC flag over APB
    task automatic set_aac(input logic v);
        logic [31:0] junk;
        junk = $urandom;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_AAC;
        pwdata  <= {junk[31:1], v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        aac_cfg = v;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Atom building
    // ------------------------------------------------------------------
    task automatic add_rand(input int n);
        repeat (n) atom_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic begin_atom();
        atom_bytes.delete();
        add_rand(int'(HEAD_BYTES));
    endtask

    // Length as 7-bit groups, MS first; cont_last sets bit 7 on the final group too
    task automatic add_len(input logic [31:0] value, input int groups, input bit cont_last);
        logic [31:0] grp;
        for (int g = groups - 1; g >= 0; g--) begin
            grp = (value >> (7 * g)) & 32'h7f;
            atom_bytes.push_back({(g != 0) || cont_last, grp[6:0]});
        end
    endtask

    task automatic add_rand_len();
        int g;
        g = $urandom_range(1, 4);
        add_len($urandom & ((32'd1 << (7 * g)) - 1), g, g == 4 && $urandom_range(3) == 0);
    endtask

    function automatic logic [7:0] wrong_tag(input logic [7:0] want);
        logic [7:0] t;
        t = 8'($urandom_range(255));
        if (t == want)
            t = ~want;
        return t;
    endfunction

    // Correct tags and fixed fields up to and including the tag 5 byte
    task automatic add_good_prefix();
        atom_bytes.push_back(TAG_ES);
        add_rand_len();
        add_rand(int'(ES_BYTES));
        atom_bytes.push_back(TAG_DEC);
        add_rand_len();
        add_rand(int'(DEC_BYTES));
        atom_bytes.push_back(TAG_SPEC);
    endtask

    // Sends the first keep bytes, marking the last one sent as the atom end
    task automatic send_atom(input int keep);
        if (keep > atom_bytes.size())
            keep = atom_bytes.size();
        for (int i = 0; i < keep; i++)
            send_byte(atom_bytes[i], i == keep - 1);
        atoms_sent++;
    endtask

    task automatic send_random_atom();
        int pick;
        int bad_at;
        int cfg_len;
        int groups;
        int cut;
        pick   = $urandom_range(99);
        bad_at = (pick < 18) ? $urandom_range(1, 3) : 0;
        begin_atom();
        if (pick >= 94) begin
            // plain noise
            atom_bytes.delete();
            add_rand($urandom_range(1, 40));
        end else begin
            atom_bytes.push_back(bad_at == 1 ? wrong_tag(TAG_ES) : TAG_ES);
            if (bad_at != 1) begin
                add_rand_len();
                add_rand(int'(ES_BYTES));
                atom_bytes.push_back(bad_at == 2 ? wrong_tag(TAG_DEC) : TAG_DEC);
                if (bad_at != 2) begin
                    add_rand_len();
                    add_rand(int'(DEC_BYTES));
                    atom_bytes.push_back(bad_at == 3 ? wrong_tag(TAG_SPEC) : TAG_SPEC);
                    if (bad_at == 0) begin
                        pick    = $urandom_range(99);
                        cfg_len = (pick < 8)  ? 0 :
                                  (pick < 85) ? $urandom_range(1, 6) : $urandom_range(7, 30);
                        groups  = $urandom_range(1, 4);
                        add_len(cfg_len, groups, groups == 4 && $urandom_range(3) == 0);
                        add_rand(cfg_len);
                    end
                end
            end
            add_rand($urandom_range(3));
        end
        cut = ($urandom_range(99) < 15) ? $urandom_range(1, atom_bytes.size())
                                        : atom_bytes.size();
        send_atom(cut);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_bad_tags();
        // wrong first tag, extremes of the byte range around it
        atom_bytes.delete();
        atom_bytes.push_back(8'h00);
        atom_bytes.push_back(8'hff);
        atom_bytes.push_back(8'h00);
        atom_bytes.push_back(8'hff);
        atom_bytes.push_back(8'h00);
        atom_bytes.push_back(TAG_DEC);
        atom_bytes.push_back(8'hff);
        send_atom(atom_bytes.size());
        // wrong second tag
        begin_atom();
        atom_bytes.push_back(TAG_ES);
        add_len(3, 1, 1'b0);
        add_rand(int'(ES_BYTES));
        atom_bytes.push_back(8'hff);
        atom_bytes.push_back(TAG_SPEC);
        send_atom(atom_bytes.size());
        // wrong third tag, a neighbouring tag value
        begin_atom();
        atom_bytes.push_back(TAG_ES);
        add_rand_len();
        add_rand(int'(ES_BYTES));
        atom_bytes.push_back(TAG_DEC);
        add_rand_len();
        add_rand(int'(DEC_BYTES));
        atom_bytes.push_back(TAG_DEC);
        add_rand(2);
        send_atom(atom_bytes.size());
    endtask

    task automatic test_empty_config();
        begin_atom();
        add_good_prefix();
        add_len(0, 2, 1'b0);
        add_rand(2);
        send_atom(atom_bytes.size());
    endtask

    task automatic test_config_endings();
        // last config byte is also the atom end: two words from one byte
        begin_atom();
        add_good_prefix();
        add_len(2, 1, 1'b0);
        atom_bytes.push_back(8'h10);
        atom_bytes.push_back(8'h08);
        send_atom(atom_bytes.size());
        // complete config followed by ignored bytes
        begin_atom();
        add_good_prefix();
        add_len(3, 1, 1'b0);
        atom_bytes.push_back(8'h12);
        atom_bytes.push_back(8'h90);
        atom_bytes.push_back(8'h55);
        atom_bytes.push_back(TAG_SPEC);
        add_rand(3);
        send_atom(atom_bytes.size());
    endtask

    task automatic test_truncation();
        // atom of a single byte
        atom_bytes.delete();
        atom_bytes.push_back(8'hff);
        send_atom(1);
        // ends after one config byte out of five
        begin_atom();
        add_good_prefix();
        add_len(5, 1, 1'b0);
        atom_bytes.push_back(8'h0b);
        send_atom(atom_bytes.size());
        // ends inside the decoder config fixed field
        begin_atom();
        add_good_prefix();
        send_atom(atom_bytes.size() - 6);
    endtask

    task automatic test_long_lengths();
        // four groups all with bit 7 set: the length stops there anyway
        begin_atom();
        atom_bytes.push_back(TAG_ES);
        add_len(32'h0fff_ffff, 4, 1'b1);
        add_rand(int'(ES_BYTES));
        atom_bytes.push_back(TAG_DEC);
        add_len(5, 4, 1'b0);
        add_rand(int'(DEC_BYTES));
        atom_bytes.push_back(TAG_SPEC);
        add_len(32'h0fff_ffff, 4, 1'b1);
        atom_bytes.push_back(8'h07);
        atom_bytes.push_back(8'hf8);
        atom_bytes.push_back(8'h00);
        send_atom(atom_bytes.size());
    endtask

    task automatic test_aac_off();
        set_aac(1'b0);
        begin_atom();
        add_good_prefix();
        add_len(2, 1, 1'b0);
        add_rand(2);
        send_atom(atom_bytes.size());
        set_aac(1'b1);
    endtask

    task automatic test_no_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (4) send_random_atom();
        tx_idle_pct = 35;
        rx_idle_pct = 35;
    endtask

    // Receiver holds off while bytes keep coming, so the queue fills up
    task automatic test_backpressure();
        tx_idle_pct = 0;
        begin_atom();
        add_good_prefix();
        add_len(40, 1, 1'b0);
        add_rand(40);
        rx_hold_req = 150;
        send_atom(atom_bytes.size());
        tx_idle_pct = 35;
    endtask

    task automatic test_random();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if ($urandom_range(4) == 0)
                set_aac(1'($urandom_range(1)));
            send_random_atom();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rate_hz = '{17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
                    17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
                    17'd7350, 17'd0, 17'd0, 17'd0};
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatches     = 0;
        bytes_sent     = 0;
        atoms_sent     = 0;
        cfg_words_seen = 0;
        summaries_seen = 0;
        status_seen    = '{default: 0};
        tx_idle_pct    = 35;
        rx_idle_pct    = 35;
        rx_hold_req    = 0;
        rx_hold_left   = 0;
        quiet_cycles   = 0;
        aac_cfg        = 1'b0;
        clear_parse();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_aac(1'b1);
        test_bad_tags();
        test_empty_config();
        test_config_endings();
        test_truncation();
        test_long_lengths();
        test_aac_off();
        test_no_idle();
        test_backpressure();
        test_random();

        // drain, then watch for stray words
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (pending_words.size() != 0)
            report_error($sformatf("%0d words never arrived", pending_words.size()));

        $display("Covered %0d bytes in %0d atoms, giving %0d config words and %0d summaries",
                 bytes_sent, atoms_sent, cfg_words_seen, summaries_seen);
        $display("Status mix ok/tag3/tag4/tag5/trunc/empty: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_BAD_TAG3], status_seen[ST_BAD_TAG4],
                 status_seen[ST_BAD_TAG5], status_seen[ST_TRUNC], status_seen[ST_EMPTY]);
        if (mismatches == 0) begin
            $display("es_descriptor_parser_core_tb: PASS");
        end else begin
            $display("es_descriptor_parser_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/esdp_pkg.sv
design/esdp_front.sv
design/esdp_queue.sv
design/esdp_back.sv
design/es_descriptor_parser_core.sv
tb/es_descriptor_parser_core_tb.sv
